### hw/rtl/mfba_pkg.sv
package mfba_pkg;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_SAME = 1'b1;

  // per-path bottleneck ceiling and saturated total
  localparam logic [13:0] BOTTLENECK_CAP = 14'd10005;
  localparam logic [16:0] FLOW_MAX       = 17'h1FFFF;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [13:0] capacity;
    logic [2:0]  source;
    logic [2:0]  sink;
  } in_item_t;

  typedef struct packed {
    logic [16:0] max_flow;
    logic        status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic run_start;
    logic copy_rd;
    logic copy_wr;
    logic bfs_init;
    logic pop;
    logic scan_rd;
    logic scan_ev;
    logic walk_init;
    logic min_rd;
    logic min_ev;
    logic upd_rdf;
    logic upd_wrf;
    logic upd_wrb;
    logic flow_add;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_req;
    logic trivial;
    logic copy_last;
    logic queue_empty;
    logic scan_last;
    logic sink_reached;
    logic par_is_src;
  } dp_sts_t;

endpackage

### hw/rtl/mfba_dp.sv
module mfba_dp #(
  parameter int NUM_VERTICES = 8,
  parameter int CAP_WIDTH    = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfba_pkg::in_item_t  in_data,
  input  mfba_pkg::dp_cmd_t   cmd,
  output mfba_pkg::dp_sts_t   sts,
  output mfba_pkg::out_item_t out_data
);
  import mfba_pkg::*;

  localparam int NV2 = NUM_VERTICES * NUM_VERTICES;
  localparam int VW  = $clog2(NUM_VERTICES);
  localparam int AW  = $clog2(NV2);
  localparam int QW  = $clog2(NUM_VERTICES + 1);
  localparam int RW  = CAP_WIDTH + 1;
  localparam int MW  = (RW > 14) ? RW : 14;

  function automatic logic [AW-1:0] f_addr(input logic [VW-1:0] u, input logic [VW-1:0] v);
    f_addr = AW'(32'(u) * NUM_VERTICES + 32'(v));
  endfunction

  // capacity memory with per-entry valid bits
  logic [CAP_WIDTH-1:0] cap_mem [NV2];
  logic [NV2-1:0]       cap_vld_r;
  logic [CAP_WIDTH-1:0] cap_rd_r;
  logic                 cap_rd_vld_r;

  // residual memory
  logic [RW-1:0] res_mem [NV2];
  logic [RW-1:0] res_rd_r;

  logic [AW-1:0] copy_idx_r;
  logic [VW-1:0] src_r, snk_r, cur_r, scan_v_r, walk_v_r;
  logic [VW-1:0] parent_r [NUM_VERTICES];
  logic [VW-1:0] queue_r [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] visited_r;
  logic [QW-1:0] head_r, tail_r;
  logic [13:0]   amount_r;
  logic [16:0]   flow_r;
  logic          status_r;
  out_item_t     out_r;

  logic          load_ok;
  logic [AW-1:0] load_addr;
  logic [VW-1:0] par;
  logic          src_oor, snk_oor;
  logic          res_rd_en, res_wr_en;
  logic [AW-1:0] res_rd_addr, res_wr_addr;
  logic [RW-1:0] res_wr_data;
  logic [17:0]   flow_sum;

  // load decode
  assign load_ok   = (32'(in_data.row) < NUM_VERTICES) && (32'(in_data.col) < NUM_VERTICES);
  assign load_addr = AW'(32'(in_data.row) * NUM_VERTICES + 32'(in_data.col));
  assign src_oor   = !(32'(in_data.source) < NUM_VERTICES);
  assign snk_oor   = !(32'(in_data.sink) < NUM_VERTICES);
  assign par       = parent_r[walk_v_r];

  // residual port selection
  always_comb begin
    res_rd_en   = cmd.scan_rd | cmd.min_rd | cmd.upd_rdf | cmd.upd_wrf;
    res_rd_addr = f_addr(par, walk_v_r);
    if (cmd.scan_rd) begin
      res_rd_addr = f_addr(cur_r, scan_v_r);
    end else if (cmd.upd_wrf) begin
      res_rd_addr = f_addr(walk_v_r, par);
    end
    res_wr_en   = cmd.copy_wr | cmd.upd_wrf | cmd.upd_wrb;
    res_wr_addr = copy_idx_r;
    res_wr_data = cap_rd_vld_r ? RW'(cap_rd_r) : '0;
    if (cmd.upd_wrf) begin
      res_wr_addr = f_addr(par, walk_v_r);
      res_wr_data = RW'(MW'(res_rd_r) - MW'(amount_r));
    end else if (cmd.upd_wrb) begin
      res_wr_addr = f_addr(walk_v_r, par);
      res_wr_data = RW'(MW'(res_rd_r) + MW'(amount_r));
    end
  end

  assign flow_sum = 18'(flow_r) + 18'(amount_r);

  // capacity memory
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      cap_mem[load_addr] <= CAP_WIDTH'(in_data.capacity);
    end
    if (cmd.copy_rd) begin
      cap_rd_r     <= cap_mem[copy_idx_r];
      cap_rd_vld_r <= cap_vld_r[copy_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= '0;
    end else if (cmd.load_wr && load_ok) begin
      cap_vld_r[load_addr] <= 1'b1;
    end
  end

  // residual memory
  always_ff @(posedge clk) begin
    if (res_wr_en) begin
      res_mem[res_wr_addr] <= res_wr_data;
    end
    if (res_rd_en) begin
      res_rd_r <= res_mem[res_rd_addr];
    end
  end

  // search and augment payload
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      src_r      <= VW'(in_data.source);
      snk_r      <= VW'(in_data.sink);
      status_r   <= (in_data.source == in_data.sink) ? ST_SAME : ST_OK;
      copy_idx_r <= '0;
    end
    if (cmd.copy_wr) begin
      copy_idx_r <= copy_idx_r + AW'(1);
    end
    if (cmd.bfs_init) begin
      queue_r[0] <= src_r;
      amount_r   <= BOTTLENECK_CAP;
    end
    if (cmd.pop) begin
      cur_r    <= queue_r[head_r[VW-1:0]];
      scan_v_r <= '0;
    end
    if (cmd.scan_ev) begin
      scan_v_r <= scan_v_r + VW'(1);
      if (!visited_r[scan_v_r] && (res_rd_r != '0)) begin
        parent_r[scan_v_r] <= cur_r;
        if (32'(tail_r) < NUM_VERTICES) begin
          queue_r[tail_r[VW-1:0]] <= scan_v_r;
        end
      end
    end
    if (cmd.walk_init) begin
      walk_v_r <= snk_r;
    end
    if (cmd.min_ev) begin
      if (MW'(res_rd_r) < MW'(amount_r)) begin
        amount_r <= 14'(res_rd_r);
      end
      walk_v_r <= par;
    end
    if (cmd.upd_wrb) begin
      walk_v_r <= par;
    end
    if (cmd.out_load) begin
      out_r <= '{max_flow: flow_r, status: status_r};
    end
  end

  // search control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      flow_r    <= '0;
    end else begin
      if (cmd.run_start) begin
        flow_r <= '0;
      end
      if (cmd.bfs_init) begin
        visited_r <= NUM_VERTICES'(1) << src_r;
        head_r    <= '0;
        tail_r    <= QW'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + QW'(1);
      end
      if (cmd.scan_ev && !visited_r[scan_v_r] && (res_rd_r != '0)) begin
        visited_r[scan_v_r] <= 1'b1;
        if (32'(tail_r) < NUM_VERTICES) begin
          tail_r <= tail_r + QW'(1);
        end
      end
      if (cmd.flow_add) begin
        flow_r <= flow_sum[17] ? FLOW_MAX : flow_sum[16:0];
      end
    end
  end

  // status to controller
  assign sts.run_req      = (in_data.req_type == REQ_RUN);
  assign sts.trivial      = (in_data.source == in_data.sink) || src_oor || snk_oor;
  assign sts.copy_last    = (copy_idx_r == AW'(NV2 - 1));
  assign sts.queue_empty  = (head_r == tail_r);
  assign sts.scan_last    = (scan_v_r == VW'(NUM_VERTICES - 1));
  assign sts.sink_reached = visited_r[snk_r];
  assign sts.par_is_src   = (par == src_r);

  assign out_data = out_r;

endmodule

### hw/rtl/mfba_ctrl.sv
module mfba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mfba_pkg::dp_sts_t sts,
  output mfba_pkg::dp_cmd_t cmd
);
  import mfba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_COPY_RD, S_COPY_WR, S_BFS_INIT, S_POP, S_SCAN_RD, S_SCAN_EV,
    S_WALK_INIT, S_MIN_RD, S_MIN_EV, S_UPD_INIT, S_UPD_RDF, S_UPD_WRF,
    S_UPD_WRB, S_FLOW, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer, out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencing
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (sts.run_req) begin
            cmd.run_start = 1'b1;
            state_nxt     = sts.trivial ? S_FIN : S_COPY_RD;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = sts.copy_last ? S_BFS_INIT : S_COPY_RD;
      end
      S_BFS_INIT: begin
        cmd.bfs_init = 1'b1;
        state_nxt    = S_POP;
      end
      S_POP: begin
        if (sts.queue_empty) begin
          state_nxt = sts.sink_reached ? S_WALK_INIT : S_FIN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = sts.scan_last ? S_POP : S_SCAN_RD;
      end
      S_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_MIN_RD;
      end
      S_MIN_RD: begin
        cmd.min_rd = 1'b1;
        state_nxt  = S_MIN_EV;
      end
      S_MIN_EV: begin
        cmd.min_ev = 1'b1;
        state_nxt  = sts.par_is_src ? S_UPD_INIT : S_MIN_RD;
      end
      S_UPD_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_UPD_RDF;
      end
      S_UPD_RDF: begin
        cmd.upd_rdf = 1'b1;
        state_nxt   = S_UPD_WRF;
      end
      S_UPD_WRF: begin
        cmd.upd_wrf = 1'b1;
        state_nxt   = S_UPD_WRB;
      end
      S_UPD_WRB: begin
        cmd.upd_wrb = 1'b1;
        state_nxt   = sts.par_is_src ? S_FLOW : S_UPD_RDF;
      end
      S_FLOW: begin
        cmd.flow_add = 1'b1;
        state_nxt    = S_BFS_INIT;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/max_flow_bfs_augment_unit.sv
// Edmonds-Karp max flow engine over an NUM_VERTICES x NUM_VERTICES graph.
// A load transfer writes one edge capacity and returns no result; the
// capacity matrix is zero after reset. A run transfer returns the total
// flow from source to sink, saturated at 131071, each augmenting path
// carrying at most 10005; source equal to sink returns 0 with status 1,
// and an out-of-range vertex returns 0 with status 0. One item is in work
// at a time. A run first copies capacities into the residual memory,
// then per search does a breadth-first scan with one residual memory
// read per neighbor checked, then walks each augmenting path from sink
// to source to find its bottleneck and again to update residuals, and
// finally registers the result; memory reads are registered, with one
// residual read and one residual write per cycle.
module max_flow_bfs_augment_unit #(
  parameter int NUM_VERTICES = 8,
  parameter int CAP_WIDTH    = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfba_pkg::out_item_t out_data
);
  import mfba_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer
  mfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // memories, queue and arithmetic
  mfba_dp #(
    .NUM_VERTICES (NUM_VERTICES),
    .CAP_WIDTH    (CAP_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // a same-vertex status never carries flow
  a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_SAME) |-> (out_data.max_flow == '0))
    else $error("same-vertex result with nonzero flow");

  // a same-vertex run with a free output goes straight to the finish state and is answered from there
  a_same_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_RUN) &&
    (in_data.source == in_data.sink) && !out_valid
    |=> ##1 out_valid && (out_data.status == ST_SAME))
    else $error("same-vertex run not answered");

  // the search never pops, scans or copies while loading
  a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_wr |-> !dp_cmd.pop && !dp_cmd.scan_ev && !dp_cmd.copy_wr)
    else $error("load overlaps run work");
`endif

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfba_pkg::*;

  localparam int NV = 8;
  localparam int STALL_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  max_flow_bfs_augment_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state: capacity matrix as the block holds it
  logic [13:0] cap_matrix [NV*NV];
  in_item_t pending_items[$];
  out_item_t flow_expected[$];
  int errors;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // edmonds-karp over a private residual copy
  function automatic out_item_t compute_max_flow(input in_item_t it);
    out_item_t res;
    int resid [NV*NV];
    int parent [NV];
    int bfs_q [NV];
    int head, tail, cur, s, t, amount, u, v;
    logic [NV-1:0] seen;
    int total;
    res.status = ST_OK;
    res.max_flow = '0;
    s = it.source;
    t = it.sink;
    total = 0;
    if (s == t) begin
      res.status = ST_SAME;
      return res;
    end
    for (int i = 0; i < NV*NV; i++) resid[i] = cap_matrix[i];
    forever begin
      seen = '0;
      seen[s] = 1'b1;
      head = 0;
      tail = 0;
      bfs_q[tail++] = s;
      while (head < tail) begin
        cur = bfs_q[head++];
        for (v = 0; v < NV; v++) begin
          if (!seen[v] && resid[cur*NV+v] > 0) begin
            parent[v] = cur;
            seen[v] = 1'b1;
            if (tail < NV) bfs_q[tail++] = v;
          end
        end
      end
      if (!seen[t]) break;
      amount = BOTTLENECK_CAP;
      for (v = t; v != s; v = parent[v])
        if (resid[parent[v]*NV+v] < amount) amount = resid[parent[v]*NV+v];
      for (v = t; v != s; v = parent[v]) begin
        u = parent[v];
        resid[u*NV+v] -= amount;
        resid[v*NV+u] += amount;
      end
      total += amount;
      if (total > FLOW_MAX) total = FLOW_MAX;
    end
    res.max_flow = total[16:0];
    return res;
  endfunction

  function automatic in_item_t make_load(input int r, input int c, input int cap);
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_type = REQ_LOAD;
    it.row = r[2:0];
    it.col = c[2:0];
    it.capacity = cap[13:0];
    return it;
  endfunction

  function automatic in_item_t make_run(input int s, input int t);
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_type = REQ_RUN;
    it.source = s[2:0];
    it.sink = t[2:0];
    return it;
  endfunction

  // random capacity: mostly moderate, some extremes and wide values
  function automatic int draw_capacity();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16383;
      2: return $urandom_range(10000, 16383);
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  // driver: one transfer at a time with a random gap before each
  int gap_left;
  bit have_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
      have_item <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV*NV; i++) cap_matrix[i] <= '0;
    end else if (in_valid && !in_stall) begin
      if (in_data.req_type == REQ_LOAD)
        cap_matrix[in_data.row*NV + in_data.col] <= in_data.capacity;
      else
        flow_expected.push_back(compute_max_flow(in_data));
    end
  end

  // receiver stall and monitor
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (flow_expected.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          out_item_t exp_r;
          exp_r = flow_expected.pop_front();
          if (out_data.max_flow !== exp_r.max_flow)
            report_mismatch($sformatf("max_flow got %0d want %0d",
                                      out_data.max_flow, exp_r.max_flow));
          if (out_data.status !== exp_r.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, exp_r.status));
        end
        stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n_runs;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, same vertex, extremes, big parallel paths
    pending_items.push_back(make_run(0, 7));
    pending_items.push_back(make_run(3, 3));
    pending_items.push_back(make_load(0, 7, 16383));
    pending_items.push_back(make_run(0, 7));
    pending_items.push_back(make_run(7, 0));
    for (int m = 1; m < 7; m++) begin
      pending_items.push_back(make_load(0, m, 16383));
      pending_items.push_back(make_load(m, 7, 16383));
    end
    pending_items.push_back(make_run(0, 7));
    pending_items.push_back(make_load(0, 7, 0));
    pending_items.push_back(make_load(3, 4, 1));
    pending_items.push_back(make_run(0, 7));
    pending_items.push_back(make_run(7, 7));
    pending_items.push_back(make_run(1, 2));

    // random: load bursts then runs between distinct or equal vertices
    n_runs = 0;
    while (pending_items.size() < 140 || n_runs < 20) begin
      int k;
      k = $urandom_range(1, 8);
      for (int j = 0; j < k; j++)
        pending_items.push_back(make_load($urandom_range(0, 7), $urandom_range(0, 7),
                                          draw_capacity()));
      if ($urandom_range(0, 9) == 0)
        pending_items.push_back(make_run($urandom_range(0, 7), $urandom_range(0, 7)));
      else begin
        int s, t;
        s = $urandom_range(0, 7);
        t = (s + $urandom_range(1, 7)) % NV;
        pending_items.push_back(make_run(s, t));
      end
      n_runs++;
    end

    wait (pending_items.size() == 0 && !in_valid);
    wait (flow_expected.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
